/* rtl/uudec_pkg.sv */
// Package for the uudecode line decoder: request, status and state codes,
// the request type from the controller to the code table, and the standard mapping.
// No dependencies.
`default_nettype none

package uudec_pkg;

  localparam int CharW         = 7;
  localparam int CodeW         = 6;
  localparam int FillW         = 7;
  localparam int CountW        = 6;
  localparam int TableEntries  = 128;
  localparam int CodeCount     = 64;

  typedef enum logic [1:0] {
    REQ_LINE  = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_TABLE = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DUP  = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic {
    KIND_DATA   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic             clear;
    logic             rd_en;
    logic [CharW-1:0] rd_chr;
    logic             wr_en;
    logic [CharW-1:0] wr_chr;
    logic [CodeW-1:0] wr_code;
  } tbl_req_t;

  function automatic logic [CodeW-1:0] std_code(input logic [CharW-1:0] chr);
    logic [CodeW-1:0] code;
    code = '0;
    if (chr >= 7'h20 && chr <= 7'h5F) begin
      code = CodeW'(chr - 7'h20);
    end else if (chr == 7'h7E) begin
      code = 6'd62;
    end
    return code;
  endfunction

endpackage

`default_nettype wire

/* rtl/uudec_code_table.sv */
// Character translation table: synchronous memory with per-entry written bits
// and a cleared flag; unwritten entries read as the standard mapping or as zero.
// Depends on uudec_pkg.
`default_nettype none

module uudec_code_table #(
  parameter int TABLE_ENTRIES = uudec_pkg::TableEntries
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  uudec_pkg::tbl_req_t             req_i,
  output logic [uudec_pkg::CodeW-1:0]     code_o
);

  localparam int AW = $clog2(TABLE_ENTRIES);

  logic [uudec_pkg::CodeW-1:0] mem_q [TABLE_ENTRIES];
  logic [uudec_pkg::CodeW-1:0] rd_data_q;
  logic [uudec_pkg::CharW-1:0] rd_chr_q;
  logic [TABLE_ENTRIES-1:0]    written_q;
  logic                        cleared_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[AW'(req_i.wr_chr)] <= req_i.wr_code;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[AW'(req_i.rd_chr)];
      rd_chr_q  <= req_i.rd_chr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
      cleared_q <= 1'b0;
    end else if (req_i.clear) begin
      written_q <= '0;
      cleared_q <= 1'b1;
    end else if (req_i.wr_en) begin
      written_q[AW'(req_i.wr_chr)] <= 1'b1;
    end
  end

  always_comb begin
    if (written_q[AW'(rd_chr_q)]) begin
      code_o = rd_data_q;
    end else if (cleared_q) begin
      code_o = '0;
    end else begin
      code_o = uudec_pkg::std_code(rd_chr_q);
    end
  end

endmodule

`default_nettype wire

/* rtl/uudec_line_ctrl.sv */
// Request sequencer: table loading, line count and group assembly, byte emission
// with end-of-line padding, and the output register. Depends on uudec_pkg.
`default_nettype none

module uudec_line_ctrl (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  wire  [7:0]                   s_axis_tdata_i,   // [6:0] char_code
  input  wire  [1:0]                   s_axis_tuser_i,   // [1:0] req_type
  input  wire                          s_axis_tlast_i,   // end_of_line
  output logic                         m_axis_tvalid_o,
  input  wire                          m_axis_tready_i,
  output logic [15:0]                  m_axis_tdata_o,   // [7:0] data_byte, [9:8] table_status
  output logic                         m_axis_tuser_o,   // result_kind
  output logic                         m_axis_tlast_o,   // last_of_line
  output uudec_pkg::tbl_req_t          tbl_req_o,
  input  wire  [uudec_pkg::CodeW-1:0]  code_i
);

  uudec_pkg::state_e              state_q, state_d;
  uudec_pkg::req_e                req_q, req_d;
  logic [uudec_pkg::CharW-1:0]    chr_q, chr_d;
  logic                           eol_q, eol_d;
  logic [uudec_pkg::FillW-1:0]    fill_q, fill_d;
  logic [uudec_pkg::CountW-1:0]   rem_q, rem_d;
  logic                           started_q, started_d;
  logic [1:0]                     phase_q, phase_d;
  logic [17:0]                    bits_q, bits_d;
  logic [23:0]                    word_q, word_d;
  logic [1:0]                     idx_q, idx_d;

  logic                           out_valid_q;
  logic [7:0]                     out_byte_q;
  uudec_pkg::status_e             out_status_q;
  uudec_pkg::kind_e               out_kind_q;
  logic                           out_last_q;

  logic                           out_free;
  logic                           out_load;
  logic [7:0]                     out_byte;
  uudec_pkg::status_e             out_status;
  uudec_pkg::kind_e               out_kind;
  logic                           out_last;
  logic                           grp;

  assign out_free = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= uudec_pkg::S_IDLE;
      req_q     <= uudec_pkg::REQ_LINE;
      chr_q     <= '0;
      eol_q     <= 1'b0;
      fill_q    <= '0;
      rem_q     <= '0;
      started_q <= 1'b0;
      phase_q   <= '0;
      bits_q    <= '0;
      word_q    <= '0;
      idx_q     <= '0;
    end else begin
      state_q   <= state_d;
      req_q     <= req_d;
      chr_q     <= chr_d;
      eol_q     <= eol_d;
      fill_q    <= fill_d;
      rem_q     <= rem_d;
      started_q <= started_d;
      phase_q   <= phase_d;
      bits_q    <= bits_d;
      word_q    <= word_d;
      idx_q     <= idx_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    req_d      = req_q;
    chr_d      = chr_q;
    eol_d      = eol_q;
    fill_d     = fill_q;
    rem_d      = rem_q;
    started_d  = started_q;
    phase_d    = phase_q;
    bits_d     = bits_q;
    word_d     = word_q;
    idx_d      = idx_q;
    tbl_req_o  = '0;
    s_axis_tready_o = 1'b0;
    out_load   = 1'b0;
    out_byte   = '0;
    out_status = uudec_pkg::ST_OK;
    out_kind   = uudec_pkg::KIND_DATA;
    out_last   = 1'b0;
    grp        = 1'b0;

    case (state_q)
      uudec_pkg::S_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          req_d = uudec_pkg::req_e'(s_axis_tuser_i);
          chr_d = s_axis_tdata_i[uudec_pkg::CharW-1:0];
          eol_d = s_axis_tlast_i;
          case (uudec_pkg::req_e'(s_axis_tuser_i))
            uudec_pkg::REQ_CLEAR: begin
              tbl_req_o.clear = 1'b1;
              fill_d = '0;
            end
            uudec_pkg::REQ_LINE, uudec_pkg::REQ_TABLE: begin
              tbl_req_o.rd_en  = 1'b1;
              tbl_req_o.rd_chr = s_axis_tdata_i[uudec_pkg::CharW-1:0];
              state_d = uudec_pkg::S_LOOK;
            end
            default: begin
            end
          endcase
        end
      end

      uudec_pkg::S_LOOK: begin
        if (req_q == uudec_pkg::REQ_TABLE) begin
          if (out_free) begin
            out_load = 1'b1;
            out_kind = uudec_pkg::KIND_STATUS;
            if (fill_q >= uudec_pkg::FillW'(uudec_pkg::CodeCount)) begin
              out_status = uudec_pkg::ST_FULL;
            end else if (code_i != '0) begin
              out_status = uudec_pkg::ST_DUP;
            end else begin
              tbl_req_o.wr_en   = 1'b1;
              tbl_req_o.wr_chr  = chr_q;
              tbl_req_o.wr_code = fill_q[uudec_pkg::CodeW-1:0];
              fill_d = fill_q + uudec_pkg::FillW'(1);
              out_status = (fill_q == uudec_pkg::FillW'(uudec_pkg::CodeCount - 1)) ?
                           uudec_pkg::ST_FULL : uudec_pkg::ST_OK;
            end
            state_d = uudec_pkg::S_IDLE;
          end
        end else begin
          word_d = '0;
          idx_d  = '0;
          if (!started_q) begin
            rem_d     = code_i;
            started_d = 1'b1;
            phase_d   = '0;
            bits_d    = '0;
          end else if (rem_q != '0) begin
            if (phase_q == 2'd3) begin
              word_d  = {bits_q, code_i};
              grp     = 1'b1;
              phase_d = '0;
              bits_d  = '0;
            end else begin
              bits_d  = {bits_q[11:0], code_i};
              phase_d = phase_q + 2'd1;
            end
          end
          if (eol_q) begin
            case (phase_d)
              2'd1:    word_d = {bits_d[5:0], 18'b0};
              2'd2:    word_d = {bits_d[11:0], 12'b0};
              2'd3:    word_d = {bits_d, 6'b0};
              default: begin
              end
            endcase
            started_d = 1'b0;
            phase_d   = '0;
            bits_d    = '0;
          end
          state_d = ((grp || eol_q) && rem_d != '0) ? uudec_pkg::S_EMIT : uudec_pkg::S_IDLE;
        end
      end

      uudec_pkg::S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          case (idx_q)
            2'd0:    out_byte = word_q[23:16];
            2'd1:    out_byte = word_q[15:8];
            default: out_byte = word_q[7:0];
          endcase
          out_last = (rem_q == uudec_pkg::CountW'(1));
          rem_d = rem_q - uudec_pkg::CountW'(1);
          idx_d = idx_q + 2'd1;
          if (rem_q == uudec_pkg::CountW'(1)) begin
            state_d = uudec_pkg::S_IDLE;
          end else if (idx_q == 2'd2) begin
            if (eol_q) begin
              word_d = '0;
              idx_d  = '0;
            end else begin
              state_d = uudec_pkg::S_IDLE;
            end
          end
        end
      end

      default: begin
        state_d = uudec_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_byte_q   <= out_byte;
      out_status_q <= out_status;
      out_kind_q   <= out_kind;
      out_last_q   <= out_last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b0, out_status_q, out_byte_q};
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

`default_nettype wire

/* rtl/uudecode_line_decoder.sv */
// Top level of the uudecode line decoder: code table memory and request sequencer.
// Depends on uudec_pkg, uudec_code_table and uudec_line_ctrl.
//
// One request is worked on at a time. A line or table character is accepted in S_IDLE,
// which reads the code table, and the entry is acted on in S_LOOK. A clear request is done
// in S_IDLE. A character that completes a group of four then emits its decoded bytes (up to
// three) in S_EMIT, and the last character of a line emits each byte still owed by the count;
// each byte leaves through a single output register, so a stalled output stalls the emission
// and the table status too. Table characters give one status transaction.
`default_nettype none

module uudecode_line_decoder #(
  parameter int TABLE_ENTRIES = uudec_pkg::TableEntries
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [7:0]  s_axis_tdata_i,   // [6:0] char_code
  input  wire  [1:0]  s_axis_tuser_i,   // [1:0] req_type
  input  wire         s_axis_tlast_i,   // end_of_line
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [7:0] data_byte, [9:8] table_status
  output logic        m_axis_tuser_o,   // result_kind
  output logic        m_axis_tlast_o    // last_of_line
);

  uudec_pkg::tbl_req_t         tbl_req;
  logic [uudec_pkg::CodeW-1:0] code;

  uudec_code_table #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (tbl_req),
    .code_o (code)
  );

  uudec_line_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .tbl_req_o       (tbl_req),
    .code_i          (code)
  );

endmodule

`default_nettype wire
